// File: src/gaussian_sum_of_uniforms_macros.svh
`ifndef GAUSSIAN_SUM_OF_UNIFORMS_MACROS_SVH
`define GAUSSIAN_SUM_OF_UNIFORMS_MACROS_SVH

// checked outside reset
`define GSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gsu_pkg.sv
`default_nettype none
package gsu_pkg;

  localparam int SUM_COUNT_DEF = 12;
  localparam int MEAN_W        = 16;
  localparam int SPREAD_W      = 12;
  localparam int SPR12_W       = 16;
  localparam int SAMPLE_W      = 18;
  localparam int SEED_W        = 31;
  localparam int QMAG_W        = SAMPLE_W - 1;

  localparam longint unsigned PM_MOD = 64'd2147483647;
  localparam logic [14:0] PM_MULT    = 15'd16807;
  localparam logic [SEED_W-1:0] SEED_RESET = 31'd423669749;

  typedef struct packed {
    logic load;
    logic step;
    logic acc;
    logic center;
    logic scale;
    logic merge;
    logic fold;
    logic recip;
    logic emit;
  } gsu_cmd_t;

endpackage
`default_nettype wire

// File: src/gsu_ctrl.sv
`default_nettype none
module gsu_ctrl import gsu_pkg::*; #(
  parameter int SUM_COUNT = SUM_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output gsu_cmd_t  cmd
);

  localparam int CNT_W     = $clog2(SUM_COUNT + 1);
  localparam int DIV_STEPS = 2;
  localparam int DIV_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_COUNT - 1);
  localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_GEN, ST_ACC, ST_CTR, ST_MUL, ST_CMB, ST_DIV, ST_OUT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] div_cnt_r;
  logic             in_stall_r;
  logic             out_valid_r;
  logic             in_accept;
  logic             out_take;

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  always_comb begin
    in_accept  = (state_r == ST_IDLE) && in_valid && !in_stall_r;
    out_take   = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
    cmd        = '0;
    cmd.load   = in_accept;
    cmd.step   = (state_r == ST_GEN);
    cmd.acc    = ((state_r == ST_GEN) && (cnt_r != '0)) || (state_r == ST_ACC);
    cmd.center = (state_r == ST_CTR);
    cmd.scale  = (state_r == ST_MUL);
    cmd.merge  = (state_r == ST_CMB);
    cmd.fold   = (state_r == ST_DIV) && (div_cnt_r == DIV_LAST);
    cmd.recip  = (state_r == ST_DIV) && (div_cnt_r == '0);
    cmd.emit   = out_take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      div_cnt_r   <= '0;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            state_r    <= ST_GEN;
            in_stall_r <= 1'b1;
            cnt_r      <= '0;
          end
        end
        ST_GEN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: state_r <= ST_CTR;
        ST_CTR: state_r <= ST_MUL;
        ST_MUL: state_r <= ST_CMB;
        ST_CMB: begin
          state_r   <= ST_DIV;
          div_cnt_r <= DIV_LAST;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r - DIV_W'(1);
          if (div_cnt_r == '0) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_take) begin
            in_stall_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/gsu_dp.sv
`default_nettype none
module gsu_dp import gsu_pkg::*; #(
  parameter int SUM_COUNT = SUM_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gsu_cmd_t            cmd,
  input  wire logic                cfg_wr_en,
  input  wire logic [SEED_W-1:0]   cfg_wr_data,
  input  wire logic [MEAN_W-1:0]   in_mean_value,
  input  wire logic [SPREAD_W-1:0] in_spread,
  output logic [SAMPLE_W-1:0]      out_sample,
  output logic [SEED_W-1:0]        out_seed_after
);

  localparam int SW    = $clog2(SUM_COUNT) + SEED_W;
  localparam longint unsigned DEN = 2 * SUM_COUNT * PM_MOD;
  localparam longint unsigned NM  = SUM_COUNT * PM_MOD;
  localparam int DW    = $clog2(DEN);
  localparam int NUM_W = DW + QMAG_W;
  localparam logic [DW-1:0] DEN_V = DW'(DEN);
  localparam logic [SW-1:0] NM_V  = SW'(NM);
  localparam logic [31:0]   MOD_V = 32'(PM_MOD);

  // quotient by 2^31-1, then by 2*SUM_COUNT through a reciprocal
  localparam int Q1_W   = NUM_W - SEED_W;
  localparam int D2     = 2 * SUM_COUNT;
  localparam int RCP_SH = Q1_W + $clog2(D2);
  localparam int RCP_W  = Q1_W + 1;
  localparam longint unsigned RCP =
    ((64'd1 << RCP_SH) + longint'(D2) - 64'd1) / longint'(D2);
  localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RCP);

  function automatic logic [SEED_W-1:0] pm_next(input logic [SEED_W-1:0] x);
    logic [45:0] p;
    logic [31:0] r;
    p = {15'd0, x} * {31'd0, PM_MULT};
    r = {17'd0, p[45:31]} + {1'b0, p[30:0]};
    if (r >= MOD_V) begin
      r = r - MOD_V;
    end
    return r[SEED_W-1:0];
  endfunction

  logic [SEED_W-1:0]   x_r;
  logic [SW-1:0]       sum_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [SPR12_W-1:0]  spr12_r;
  logic [SW:0]         cmag_r;
  logic                cneg_r;
  logic [NUM_W-1:0]    meand_r;
  logic [NUM_W-1:0]    prod_r;
  logic [NUM_W-1:0]    tmag_r;
  logic [Q1_W-1:0]     q1_r;
  logic [QMAG_W-1:0]   qmag_r;
  logic                qneg_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SEED_W-1:0]   seed_r;

  logic [SPR12_W-1:0]  spr12;
  logic signed [SW+1:0] cdiff;
  logic [SW:0]         cmag;
  logic [NUM_W-1:0]    meand;
  logic [NUM_W-1:0]    prod;
  logic [NUM_W:0]      tot;
  logic                tneg;
  logic [NUM_W:0]      tmag;
  logic [SEED_W:0]     fsum;
  logic                fge;
  logic [Q1_W-1:0]     q1;
  logic [2*Q1_W:0]     qprod;
  logic [SAMPLE_W-1:0] qext;

  always_comb begin
    spr12 = {1'b0, in_spread, 3'b000} + {2'b00, in_spread, 2'b00};
    cdiff = $signed({1'b0, sum_r, 1'b0}) - $signed({2'b00, NM_V});
    cmag  = cdiff[SW+1] ? (SW+1)'(-cdiff) : cdiff[SW:0];
    meand = {{(NUM_W-MEAN_W){1'b0}}, mean_r} * {{(NUM_W-DW){1'b0}}, DEN_V};
    prod  = {{(NUM_W-SW-1){1'b0}}, cmag_r} * {{(NUM_W-SPR12_W){1'b0}}, spr12_r};
    tot   = cneg_r ? ({1'b0, meand_r} - {1'b0, prod_r}) : ({1'b0, meand_r} + {1'b0, prod_r});
    tneg  = cneg_r & tot[NUM_W];
    tmag  = tneg ? -tot : tot;
    // 2^31 folds to 1 modulo 2^31-1, so high part plus low part needs one correction
    fsum  = {1'b0, tmag_r[SEED_W-1:0]} +
            {{(SEED_W+1-Q1_W){1'b0}}, tmag_r[NUM_W-1:SEED_W]};
    fge   = (fsum >= MOD_V);
    q1    = tmag_r[NUM_W-1:SEED_W] + Q1_W'(fge);
    qprod = {{RCP_W{1'b0}}, q1_r} * {{Q1_W{1'b0}}, RCP_V};
    qext  = {1'b0, qmag_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= SEED_RESET;
    end else if (cfg_wr_en) begin
      x_r <= cfg_wr_data;
    end else if (cmd.step) begin
      x_r <= pm_next(x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mean_r  <= in_mean_value;
      spr12_r <= spr12;
      sum_r   <= '0;
    end else if (cmd.acc) begin
      sum_r <= sum_r + SW'(x_r);
    end
    if (cmd.center) begin
      cmag_r  <= cmag;
      cneg_r  <= cdiff[SW+1];
      meand_r <= meand;
    end
    if (cmd.scale) begin
      prod_r <= prod;
    end
    if (cmd.merge) begin
      qneg_r <= tneg;
      tmag_r <= tmag[NUM_W-1:0];
    end
    if (cmd.fold) begin
      q1_r <= q1;
    end
    if (cmd.recip) begin
      qmag_r <= qprod[RCP_SH+QMAG_W-1:RCP_SH];
    end
    if (cmd.emit) begin
      sample_r <= qneg_r ? -qext : qext;
      seed_r   <= x_r;
    end
  end

  assign out_sample     = sample_r;
  assign out_seed_after = seed_r;

endmodule
`default_nettype wire

// File: src/gaussian_sum_of_uniforms.sv
// Approximately normal integer samples from a sum of uniforms. Each accepted
// beat of mean and spread steps a minimal standard multiplicative congruential
// generator (x = 16807*x mod 2^31-1) SUM_COUNT times, one step per cycle, sums
// the states, centers and scales the sum, and divides exactly by
// 2*SUM_COUNT*(2^31-1): the DIV state first folds the quotient by 2^31-1 and
// then takes the quotient by 2*SUM_COUNT through a reciprocal multiply. The
// beat passes the GEN, ACC, CTR, MUL, CMB, DIV and OUT states before its result
// is registered, the generator steps in GEN taking most of that time, and one
// item is in flight at a time. The result sits in an output register, so a new
// beat is taken while the last result still waits; a stalled result holds the
// next item in its last cycle. A write on the cfg port reloads the generator
// state and must come while the block is idle.
`default_nettype none
module gaussian_sum_of_uniforms import gsu_pkg::*; #(
  parameter int SUM_COUNT = SUM_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [SEED_W-1:0]   cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [MEAN_W-1:0]   in_mean_value,
  input  wire logic [SPREAD_W-1:0] in_spread,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SAMPLE_W-1:0]      out_sample,
  output logic [SEED_W-1:0]        out_seed_after
);

  gsu_cmd_t cmd;

  gsu_ctrl #(.SUM_COUNT(SUM_COUNT)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gsu_dp #(.SUM_COUNT(SUM_COUNT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_mean_value  (in_mean_value),
    .in_spread      (in_spread),
    .out_sample     (out_sample),
    .out_seed_after (out_seed_after)
  );

endmodule
`default_nettype wire

// File: src/gsu_check.sv
`default_nettype none
`include "gaussian_sum_of_uniforms_macros.svh"
module gsu_check import gsu_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [SAMPLE_W-1:0] out_sample,
  input wire logic [SEED_W-1:0]   out_seed_after
);

  // no result survives reset
  `GSU_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

  // a waiting result holds its beat
  `GSU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_seed_after), "stalled result changed")

  // one item in flight: an accepted beat closes the input
  `GSU_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input open while busy")

  // a fresh result only ends a busy stretch
  `GSU_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall) && !in_stall, "result without work")

endmodule

bind gaussian_sum_of_uniforms gsu_check u_check (.*);
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import gsu_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;
  localparam int PHASE_ITEMS  = 400;
  localparam int SEED_EVERY   = 100;

  localparam logic [SEED_W-1:0]   SEED_ZERO  = '0;
  localparam logic [SEED_W-1:0]   SEED_MOD   = 31'h7FFF_FFFF;
  localparam logic [SEED_W-1:0]   SEED_MIN   = 31'd1;
  localparam logic [SEED_W-1:0]   SEED_MAX   = 31'd2147483646;
  localparam logic [MEAN_W-1:0]   MEAN_MAX   = '1;
  localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SEED_W-1:0]   seed_after;
  } sample_t;

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                cfg_wr_en     = 1'b0;
  logic [SEED_W-1:0]   cfg_wr_data   = '0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [MEAN_W-1:0]   in_mean_value = '0;
  logic [SPREAD_W-1:0] in_spread     = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [SAMPLE_W-1:0] out_sample;
  logic [SEED_W-1:0]   out_seed_after;

  logic [SEED_W-1:0] gen_state = SEED_RESET;
  sample_t pending_samples[$];
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int requests_sent = 0;
  int samples_checked = 0;
  int seeds_loaded = 0;

  gaussian_sum_of_uniforms dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mean_value  (in_mean_value),
    .in_spread      (in_spread),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_seed_after (out_seed_after)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sample_t next_gaussian(input logic [MEAN_W-1:0] m,
                                            input logic [SPREAD_W-1:0] s);
    longint unsigned x;
    longint total;
    longint num;
    longint den;
    longint quot;
    sample_t r;
    x = 64'(gen_state);
    total = 0;
    for (int i = 0; i < SUM_COUNT_DEF; i++) begin
      x = (x * 64'(PM_MULT)) % PM_MOD;
      total += longint'(x);
    end
    gen_state = x[SEED_W-1:0];
    den = longint'(2 * SUM_COUNT_DEF) * longint'(PM_MOD);
    num = (longint'(2) * total - longint'(SUM_COUNT_DEF) * longint'(PM_MOD))
          * longint'(s) * longint'(12);
    num += longint'(m) * den;
    quot = num / den;
    r.sample = quot[SAMPLE_W-1:0];
    r.seed_after = x[SEED_W-1:0];
    return r;
  endfunction

  function automatic void check_sample(input logic [SAMPLE_W-1:0] smp,
                                       input logic [SEED_W-1:0] sd);
    sample_t want;
    if (pending_samples.size() == 0) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("unexpected beat: sample %0d seed_after %0d", $signed(smp), sd);
      return;
    end
    want = pending_samples.pop_front();
    samples_checked++;
    if (smp !== want.sample || sd !== want.seed_after) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("mismatch: sample exp %0d got %0d, seed_after exp %0d got %0d",
                 $signed(want.sample), $signed(smp), want.seed_after, sd);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_sample(out_sample, out_seed_after);
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(input logic [MEAN_W-1:0] m, input logic [SPREAD_W-1:0] s);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_mean_value <= m;
    in_spread <= s;
    do @(posedge clk); while (in_stall);
    pending_samples.push_back(next_gaussian(m, s));
    requests_sent++;
  endtask

  task automatic send_random();
    logic [MEAN_W-1:0] m;
    logic [SPREAD_W-1:0] s;
    m = MEAN_W'($urandom_range(MEAN_MAX));
    s = SPREAD_W'($urandom_range(SPREAD_MAX));
    case ($urandom_range(7))
      0: m = '0;
      1: m = MEAN_MAX;
      2: s = '0;
      3: s = SPREAD_MAX;
      default: ;
    endcase
    send_request(m, s);
  endtask

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_seed(input logic [SEED_W-1:0] v);
    wait_drained(SETTLE);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gen_state = v;
    seeds_loaded++;
  endtask

  task automatic test_field_extremes();
    idle_pct = 0;
    stall_pct <= 0;
    send_request('0, '0);
    send_request(MEAN_MAX, '0);
    send_request('0, SPREAD_MAX);
    send_request(MEAN_MAX, SPREAD_MAX);
    send_request(16'h8000, 12'h800);
    send_request(16'h5555, 12'hAAA);
    send_request(16'hAAAA, 12'h555);
    send_request(16'd1, 12'd1);
  endtask

  task automatic test_seed_special();
    load_seed(SEED_ZERO);
    send_request('0, SPREAD_MAX);
    send_request(MEAN_MAX, SPREAD_MAX);
    send_request(16'd100, '0);
    load_seed(SEED_MOD);
    send_request('0, SPREAD_MAX);
    send_request(16'd500, 12'd7);
    load_seed(SEED_MIN);
    send_request('0, SPREAD_MAX);
    send_request(MEAN_MAX, SPREAD_MAX);
    load_seed(SEED_MAX);
    send_request('0, SPREAD_MAX);
    send_request(MEAN_MAX, SPREAD_MAX);
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    logic [SEED_W-1:0] v;
    idle_pct = idle;
    stall_pct <= stall;
    for (int i = 0; i < n; i++) begin
      if (i % SEED_EVERY == SEED_EVERY - 1) begin
        case ($urandom_range(3))
          0: v = SEED_MIN;
          1: v = SEED_MAX;
          default: v = SEED_W'($urandom_range(SEED_MAX, SEED_MIN));
        endcase
        load_seed(v);
      end
      send_random();
    end
  endtask

  task automatic test_output_hold();
    idle_pct = 0;
    stall_pct <= 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (20) send_random();
  endtask

  task automatic test_sender_pause();
    idle_pct = 0;
    stall_pct <= 30;
    repeat (10) send_random();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (10) send_random();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_seed_special();
    test_random_phase(PHASE_ITEMS, 0, 0);
    test_random_phase(PHASE_ITEMS, 49, 0);
    test_output_hold();
    test_random_phase(PHASE_ITEMS, 0, 49);
    test_sender_pause();
    test_random_phase(PHASE_ITEMS, 32, 32);
    wait_drained(DRAIN_CYCLES);
    $display("covered %0d requests, %0d samples compared, %0d seed loads (zero and 2^31-1 too)",
             requests_sent, samples_checked, seeds_loaded);
    $display("idle/stall mixes none, sender, receiver, both; %0d-cycle output hold; %0d errors",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
